// ----- rtl/core/art_pkg.sv -----
`timescale 1ns / 1ps
package art_pkg;

  localparam int unsigned TABLE_DEPTH = 8;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRIES = 1'd1;

  typedef enum logic [2:0] {
    EV_QUEUED  = 3'd0,
    EV_ACKED   = 3'd1,
    EV_RETRY   = 3'd2,
    EV_FAILED  = 3'd3,
    EV_UNKNOWN = 3'd4,
    EV_FULL    = 3'd5
  } ev_kind_e;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] tag;
    logic [31:0] sent_time;
    logic [3:0]  retries;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    ev_kind_e    kind;
    logic [31:0] id;
    logic [15:0] tag;
    logic [3:0]  retries;
  } event_t;

endpackage

// ----- rtl/core/art_cell.sv -----
`timescale 1ns / 1ps
module art_cell (
  input  logic               clk_i,
  input  art_pkg::cell_ctl_t ctl_i,
  input  art_pkg::entry_t    ins_i,
  input  art_pkg::entry_t    nbr_i,
  output art_pkg::entry_t    ent_o
);
  import art_pkg::*;

  entry_t ent_q, ent_d;

  // load wins over shift: the tail cell takes the rotated head entry
  always_comb begin
    ent_d = ent_q;
    if (ctl_i.load) begin
      ent_d = ins_i;
    end else if (ctl_i.shift) begin
      ent_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ----- rtl/core/ack_retry_tracker_unit.sv -----
`timescale 1ns / 1ps
// channel  dir  tdata (low bit up)                           tuser        tlast
// s_axis   in   message_tag, acked_id, time_now_ms           opcode       -
// m_axis   out  msg_id, event_tag, retries_remaining, 0      event_kind   last_of_run
// cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i (plain write)
//
// A send goes through the flush state. An ack or tick first scans every entry:
// the row of cells rotates by one per cycle and the head cell is examined each step.
// Reset empties the table and clears the id counter; no clearing pass.
// A scan step holds while an event waits and the output register is blocked.
module ack_retry_tracker_unit #(
  parameter int unsigned TableDepth = art_pkg::TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [79:0]                   s_axis_tdata,  // message_tag, acked_id, time_now_ms
  input  logic [1:0]                    s_axis_tuser,  // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [55:0]                   m_axis_tdata,  // msg_id, event_tag, retries, pad
  output logic [2:0]                    m_axis_tuser,  // event_kind
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [art_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i
);
  import art_pkg::*;

  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned IW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned NW = RES_CNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [1:0]    op_q, op_d;
  logic [31:0]   acked_q, acked_d;
  logic [31:0]   now_q, now_d;
  logic [31:0]   timeout_q;
  logic [3:0]    maxret_q;
  logic [31:0]   id_q, id_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] iter_q, iter_d;
  logic [NW-1:0] ncnt_q, ncnt_d;
  logic          pend_v_q, pend_v_d;
  event_t        pend_q, pend_d;
  logic          out_v_q, out_v_d;
  event_t        out_q, out_d;
  logic          out_last_q, out_last_d;

  entry_t    cell_ent [TableDepth];
  entry_t    cell_nbr [TableDepth];
  cell_ctl_t cell_ctl [TableDepth];
  entry_t    ins_ent;

  logic [15:0] in_tag;
  logic [31:0] in_acked, in_now;
  logic        accept, full, send_ok;
  logic [31:0] id_inc;
  entry_t      head, kept;
  logic [31:0] age;
  logic        ev_v, drop, step, out_free;
  event_t      ev;
  logic        push, push_last;
  event_t      push_ev;
  logic [IW-1:0] tail_idx, app_idx;

  assign in_tag   = s_axis_tdata[15:0];
  assign in_acked = s_axis_tdata[47:16];
  assign in_now   = s_axis_tdata[79:48];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign full     = (count_q >= CW'(TableDepth));
  assign send_ok  = accept && (s_axis_tuser == OP_SEND) && !full;
  assign id_inc   = (id_q + 32'd1 == 32'd0) ? 32'd1 : id_q + 32'd1;
  assign out_free = !out_v_q || m_axis_tready;
  assign tail_idx = IW'(count_q - CW'(1));
  assign app_idx  = count_q[IW-1:0];

  assign head = cell_ent[0];
  assign age  = now_q - head.sent_time;

  // examine the head entry
  always_comb begin
    ev_v = 1'b0;
    ev   = '{kind: EV_ACKED, id: head.id, tag: head.tag, retries: head.retries};
    drop = 1'b0;
    kept = head;
    if (state_q == ST_SCAN && ncnt_q < NW'(MAX_RESULTS)) begin
      if (op_q == OP_ACK) begin
        if (head.id == acked_q) begin
          ev_v = 1'b1;
          drop = 1'b1;
        end
      end else if (age > timeout_q) begin
        ev_v = 1'b1;
        if (head.retries != 4'd0) begin
          kept.retries   = head.retries - 4'd1;
          kept.sent_time = now_q;
          ev.kind        = EV_RETRY;
          ev.retries     = head.retries - 4'd1;
        end else begin
          drop       = 1'b1;
          ev.kind    = EV_FAILED;
          ev.retries = 4'd0;
        end
      end
    end
  end

  assign step = (state_q == ST_SCAN) && !(ev_v && pend_v_q && !out_free);

  assign ins_ent = send_ok ?
      entry_t'{id: id_inc, tag: in_tag, sent_time: in_now, retries: maxret_q} : kept;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    if (i + 1 < TableDepth) begin : g_nbr
      assign cell_nbr[i] = cell_ent[i+1];
    end else begin : g_end
      assign cell_nbr[i] = '0;
    end
    assign cell_ctl[i].shift = step;
    assign cell_ctl[i].load  = (send_ok && app_idx == IW'(i)) ||
                               (step && !drop && tail_idx == IW'(i));
    art_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (cell_ctl[i]),
      .ins_i (ins_ent),
      .nbr_i (cell_nbr[i]),
      .ent_o (cell_ent[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    acked_d   = acked_q;
    now_d     = now_q;
    id_d      = id_q;
    count_d   = count_q;
    iter_d    = iter_q;
    ncnt_d    = ncnt_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    push      = 1'b0;
    push_last = 1'b0;
    push_ev   = pend_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = s_axis_tuser;
          acked_d = in_acked;
          now_d   = in_now;
          iter_d  = count_q;
          ncnt_d  = '0;
          unique case (s_axis_tuser)
            OP_SEND: begin
              pend_v_d = 1'b1;
              ncnt_d   = NW'(1);
              state_d  = ST_FLUSH;
              if (full) begin
                pend_d = '{kind: EV_FULL, id: 32'd0, tag: in_tag, retries: 4'd0};
              end else begin
                id_d    = id_inc;
                count_d = count_q + CW'(1);
                pend_d  = '{kind: EV_QUEUED, id: id_inc, tag: in_tag, retries: maxret_q};
              end
            end
            OP_ACK, OP_TICK: begin
              state_d = (count_q == '0) ? ST_FLUSH : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (step) begin
          if (ev_v) begin
            // release the older event, keep the new one until the next event or the run ends
            push     = pend_v_q;
            pend_d   = ev;
            pend_v_d = 1'b1;
            ncnt_d   = ncnt_q + NW'(1);
          end
          if (drop) begin
            count_d = count_q - CW'(1);
          end
          iter_d = iter_q - CW'(1);
          if (iter_q == CW'(1)) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_v_q) begin
          if (out_free) begin
            push      = 1'b1;
            push_last = 1'b1;
            pend_v_d  = 1'b0;
            state_d   = ST_IDLE;
          end
        end else if (op_q == OP_ACK && ncnt_q == '0) begin
          if (out_free) begin
            push      = 1'b1;
            push_last = 1'b1;
            push_ev   = '{kind: EV_UNKNOWN, id: acked_q, tag: 16'd0, retries: 4'd0};
            state_d   = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_v_d    = out_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (push) begin
      out_v_d    = 1'b1;
      out_d      = push_ev;
      out_last_d = push_last;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      id_q      <= '0;
      count_q   <= '0;
      iter_q    <= '0;
      ncnt_q    <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      timeout_q <= 32'd3000;
      maxret_q  <= 4'd3;
    end else begin
      state_q  <= state_d;
      id_q     <= id_d;
      count_q  <= count_d;
      iter_q   <= iter_d;
      ncnt_q   <= ncnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
          CFG_RETRIES: maxret_q  <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    acked_q    <= acked_d;
    now_q      <= now_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0, out_q.retries, out_q.tag, out_q.id};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q <= CW'(TableDepth))
    else $error("entry count above table depth");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == ST_IDLE |-> !pend_v_q)
    else $error("pending event left behind at idle");

  a_scan_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == ST_SCAN |-> iter_q != '0 && iter_q <= count_q)
    else $error("scan running with no steps left");

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ncnt_q <= NW'(MAX_RESULTS))
    else $error("event count above result limit");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
      push |-> out_free)
    else $error("output register overwritten");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import art_pkg::*;

  localparam logic [1:0] OP_NOOP = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] tag;
    logic [31:0] acked;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    event_t ev;
    logic   last;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // message_tag, acked_id, time_now_ms
  logic [1:0]  s_axis_tuser = '0;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // msg_id, event_tag, retries_remaining, pad
  logic [2:0]  m_axis_tuser;       // event_kind
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  ack_retry_tracker_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // tracker shadow: configuration, id counter and pending-ack table
  logic [31:0] cfg_timeout = 32'd3000;
  logic [3:0]  cfg_retries = 4'd3;
  logic [31:0] id_ctr = '0;
  int          held_count = 0;
  entry_t      held_msgs[TABLE_DEPTH];

  cmd_t     pending_cmds[$];
  outcome_t expected_events[$];

  bit in_beat = 1'b0;
  bit out_beat = 1'b0;
  bit src_calm = 1'b0;
  bit snk_calm = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;
  int errors = 0;
  int idle_cycles = 0;
  int cmds_issued = 0;
  int settings_used = 1;
  int ev_seen[6];
  logic [31:0] clock_ms;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int pick_gap(inout bit calm);
    int r;
    if ($urandom_range(0, 31) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic outcome_t make_outcome(ev_kind_e kind, logic [31:0] id,
                                            logic [15:0] tag, logic [3:0] left);
    outcome_t o;
    o.ev.kind    = kind;
    o.ev.id      = id;
    o.ev.tag     = tag;
    o.ev.retries = left;
    o.last       = 1'b0;
    return o;
  endfunction

  task automatic drop_msg(input int pos);
    for (int j = pos; j + 1 < held_count; j++) held_msgs[j] = held_msgs[j + 1];
    held_count--;
  endtask

  task automatic predict_events(input cmd_t c);
    outcome_t    batch[$];
    int          i;
    logic [31:0] age;
    if (c.op == OP_SEND) begin
      if (held_count >= TABLE_DEPTH) begin
        batch.insert(batch.size(), make_outcome(EV_FULL, 32'd0, c.tag, 4'd0));
      end else begin
        id_ctr++;
        if (id_ctr == 32'd0) id_ctr = 32'd1;
        held_msgs[held_count] = '{id: id_ctr, tag: c.tag, sent_time: c.now,
                                  retries: cfg_retries};
        held_count++;
        batch.insert(batch.size(), make_outcome(EV_QUEUED, id_ctr, c.tag, cfg_retries));
      end
    end else if (c.op == OP_ACK) begin
      i = 0;
      while (i < held_count && batch.size() < MAX_RESULTS) begin
        if (held_msgs[i].id == c.acked) begin
          batch.insert(batch.size(), make_outcome(EV_ACKED, held_msgs[i].id,
                                                  held_msgs[i].tag, held_msgs[i].retries));
          drop_msg(i);
        end else begin
          i++;
        end
      end
      if (batch.size() == 0)
        batch.insert(batch.size(), make_outcome(EV_UNKNOWN, c.acked, 16'd0, 4'd0));
    end else if (c.op == OP_TICK) begin
      i = 0;
      while (i < held_count && batch.size() < MAX_RESULTS) begin
        age = c.now - held_msgs[i].sent_time;
        if (age <= cfg_timeout) begin
          i++;
        end else if (held_msgs[i].retries > 4'd0) begin
          held_msgs[i].retries--;
          held_msgs[i].sent_time = c.now;
          batch.insert(batch.size(), make_outcome(EV_RETRY, held_msgs[i].id,
                                                  held_msgs[i].tag, held_msgs[i].retries));
          i++;
        end else begin
          batch.insert(batch.size(), make_outcome(EV_FAILED, held_msgs[i].id,
                                                  held_msgs[i].tag, 4'd0));
          drop_msg(i);
        end
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) expected_events.insert(expected_events.size(), batch[k]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // accept beats on both sides, predict, compare, watch for a hang
  always @(posedge clk_i) begin
    outcome_t want;
    cmd_t     c;
    if (!rst_ni) begin
      in_beat  = 1'b0;
      out_beat = 1'b0;
    end else begin
      in_beat  = s_axis_tvalid && s_axis_tready;
      out_beat = m_axis_tvalid && m_axis_tready;
      if (in_beat) begin
        c = pending_cmds.pop_front();
        predict_events(c);
      end
      if (out_beat) begin
        if (m_axis_tuser < 3'd6) ev_seen[m_axis_tuser]++;
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event beat, expected none, got kind %0d id %0h",
                   $time, m_axis_tuser, m_axis_tdata[31:0]);
          errors++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 32'(want.ev.kind), 32'(m_axis_tuser));
          check_field("msg_id", want.ev.id, m_axis_tdata[31:0]);
          check_field("event_tag", 32'(want.ev.tag), 32'(m_axis_tdata[47:32]));
          check_field("retries_remaining", 32'(want.ev.retries), 32'(m_axis_tdata[51:48]));
          check_field("pad", 32'd0, 32'(m_axis_tdata[55:52]));
          check_field("last_of_run", 32'(want.last), 32'(m_axis_tlast));
        end
      end
      if (in_beat || out_beat || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d events outstanding",
                 $time, STALL_LIMIT, expected_events.size());
        $display("ack_retry_tracker_unit verification failed");
        $finish;
      end
    end
  end

  // command driver: hold a beat until taken, insert random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_beat)) begin
      if (in_beat) src_gap = pick_gap(src_calm);
      if (src_gap > 0 || pending_cmds.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (src_gap > 0) src_gap--;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_cmds[0].now, pending_cmds[0].acked, pending_cmds[0].tag};
        s_axis_tuser  <= pending_cmds[0].op;
      end
    end
  end

  // event sink: stall at random points
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (snk_gap > 0) begin
        m_axis_tready <= 1'b0;
        snk_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) snk_gap = pick_gap(snk_calm);
      end
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic [15:0] tag,
                          input logic [31:0] acked, input logic [31:0] now);
    cmd_t c;
    while (pending_cmds.size() >= 2) @(negedge clk_i);
    c.op    = op;
    c.tag   = tag;
    c.acked = acked;
    c.now   = now;
    pending_cmds.insert(pending_cmds.size(), c);
    cmds_issued++;
  endtask

  task automatic drain;
    while (pending_cmds.size() != 0 || expected_events.size() != 0) @(negedge clk_i);
    // a scan with no events may still be running
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TIMEOUT) cfg_timeout = val;
    else cfg_retries = val[3:0];
    @(negedge clk_i);
  endtask

  task automatic set_policy(input logic [31:0] timeout, input logic [3:0] retries);
    drain();
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_RETRIES, {28'd0, retries});
    settings_used++;
  endtask

  task automatic run_random(input int count);
    int          r;
    logic [31:0] pick;
    logic [31:0] step;
    clock_ms = $urandom();
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        clock_ms += $urandom_range(0, 20);
        push_cmd(OP_SEND, 16'($urandom_range(0, 16'hFFFF)), $urandom(), clock_ms);
      end else if (r < 65) begin
        if (held_count > 0 && $urandom_range(0, 3) != 0)
          pick = held_msgs[$urandom_range(0, held_count - 1)].id;
        else
          pick = $urandom();
        push_cmd(OP_ACK, 16'($urandom_range(0, 16'hFFFF)), pick, $urandom());
      end else if (r < 95) begin
        if (cfg_timeout < 32'd100000) step = $urandom_range(0, 2 * cfg_timeout + 2);
        else step = $urandom();
        clock_ms += step;
        // now and then a wild timestamp to age everything
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
        push_cmd(OP_TICK, 16'($urandom_range(0, 16'hFFFF)), $urandom(), clock_ms);
      end else begin
        push_cmd(OP_NOOP, 16'($urandom_range(0, 16'hFFFF)), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    logic [31:0] t0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: default policy, timestamps crossing the 32-bit wrap
    t0 = 32'hFFFF_F000;
    push_cmd(OP_NOOP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(OP_ACK, 16'h0000, 32'hFFFF_FFFF, t0);
    push_cmd(OP_TICK, 16'h0000, 32'h0000_0000, t0);
    for (int k = 0; k < TABLE_DEPTH + 1; k++) begin
      if (k == 0) push_cmd(OP_SEND, 16'h0000, 32'd0, t0);
      else if (k == 1) push_cmd(OP_SEND, 16'hFFFF, 32'd0, t0);
      else push_cmd(OP_SEND, 16'($urandom_range(0, 16'hFFFF)), 32'd0, t0);
    end
    push_cmd(OP_ACK, 16'd0, 32'd3, t0);
    push_cmd(OP_ACK, 16'd0, 32'd0, t0);
    push_cmd(OP_TICK, 16'd0, 32'd0, t0 + 32'd3000);
    push_cmd(OP_TICK, 16'd0, 32'd0, t0 + 32'd3001);
    push_cmd(OP_TICK, 16'd0, 32'd0, t0 + 32'd6002);
    push_cmd(OP_TICK, 16'd0, 32'd0, t0 + 32'd9003);
    push_cmd(OP_TICK, 16'd0, 32'd0, t0 + 32'd12004);
    run_random(40);

    set_policy(32'd0, 4'd0);
    run_random(50);
    set_policy(32'hFFFF_FFFF, 4'd15);
    run_random(50);
    for (int p = 0; p < 4; p++) begin
      set_policy(32'($urandom_range(1, 2000)), 4'($urandom_range(0, 15)));
      run_random(50);
    end

    drain();
    $display("%0d commands under %0d timeout/retry settings", cmds_issued, settings_used);
    $display("events: queued %0d acked %0d retransmit %0d failed %0d unknown %0d full %0d",
             ev_seen[0], ev_seen[1], ev_seen[2], ev_seen[3], ev_seen[4], ev_seen[5]);
    if (errors == 0) begin
      $display("ack_retry_tracker_unit verification clean");
    end else begin
      $display("ack_retry_tracker_unit verification failed");
    end
    $finish;
  end

endmodule
